>>> rtl/mqd_pkg.sv
// ----------------------------------------------------------------------------
// MQ decoder package
// Sizes, probability estimation table and shared types.
// ----------------------------------------------------------------------------
package mqd_pkg;

    localparam int NUM_CONTEXTS = 19;
    localparam int QUEUE_DEPTH  = 16;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int NSTATES      = 47;

    localparam logic [2:0] CMD_PUSH      = 3'd0;
    localparam logic [2:0] CMD_CLEAR     = 3'd1;
    localparam logic [2:0] CMD_START_MQ  = 3'd2;
    localparam logic [2:0] CMD_START_RAW = 3'd3;
    localparam logic [2:0] CMD_DEC_MQ    = 3'd4;
    localparam logic [2:0] CMD_DEC_RAW   = 3'd5;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    function automatic logic [6:0] ctx_init(input int k);
        logic [6:0] v;
        v = 7'd0;
        if (k == 0)  v = 7'd4;
        if (k == 17) v = 7'd3;
        if (k == 18) v = 7'd46;
        return v;
    endfunction

    function automatic logic [15:0] prob_qe(input logic [5:0] i);
        logic [15:0] q;
        case (i)
            6'd0, 6'd6, 6'd14, 6'd46: q = 16'h5601;
            6'd1, 6'd19:              q = 16'h3401;
            6'd2, 6'd25:              q = 16'h1801;
            6'd3, 6'd30:              q = 16'h0ac1;
            6'd4, 6'd33:              q = 16'h0521;
            6'd5, 6'd36:              q = 16'h0221;
            6'd7, 6'd15:              q = 16'h5401;
            6'd8, 6'd17:              q = 16'h4801;
            6'd9, 6'd18:              q = 16'h3801;
            6'd10, 6'd20:             q = 16'h3001;
            6'd11, 6'd22:             q = 16'h2401;
            6'd12, 6'd24:             q = 16'h1c01;
            6'd13, 6'd26:             q = 16'h1601;
            6'd16:                    q = 16'h5101;
            6'd21:                    q = 16'h2801;
            6'd23:                    q = 16'h2201;
            6'd27:                    q = 16'h1401;
            6'd28:                    q = 16'h1201;
            6'd29:                    q = 16'h1101;
            6'd31:                    q = 16'h09c1;
            6'd32:                    q = 16'h08a1;
            6'd34:                    q = 16'h0441;
            6'd35:                    q = 16'h02a1;
            6'd37:                    q = 16'h0141;
            6'd38:                    q = 16'h0111;
            6'd39:                    q = 16'h0085;
            6'd40:                    q = 16'h0049;
            6'd41:                    q = 16'h0025;
            6'd42:                    q = 16'h0015;
            6'd43:                    q = 16'h0009;
            6'd44:                    q = 16'h0005;
            6'd45:                    q = 16'h0001;
            default:                  q = 16'h5601;
        endcase
        return q;
    endfunction

    function automatic logic [5:0] next_mps(input logic [5:0] i);
        logic [5:0] n;
        case (i)
            6'd5:         n = 6'd38;
            6'd13:        n = 6'd29;
            6'd44, 6'd45: n = 6'd45;
            6'd46:        n = 6'd46;
            default:      n = i + 6'd1;
        endcase
        return n;
    endfunction

    function automatic logic [5:0] next_lps(input logic [5:0] i);
        logic [5:0] n;
        case (i)
            6'd0:  n = 6'd1;   6'd1:  n = 6'd6;   6'd2:  n = 6'd9;
            6'd3:  n = 6'd12;  6'd4:  n = 6'd29;  6'd5:  n = 6'd33;
            6'd6:  n = 6'd6;   6'd7:  n = 6'd14;  6'd8:  n = 6'd14;
            6'd9:  n = 6'd14;  6'd10: n = 6'd17;  6'd11: n = 6'd18;
            6'd12: n = 6'd20;  6'd13: n = 6'd21;  6'd14: n = 6'd14;
            6'd15: n = 6'd14;  6'd16: n = 6'd15;  6'd17: n = 6'd16;
            6'd18: n = 6'd17;  6'd19: n = 6'd18;  6'd20: n = 6'd19;
            6'd21: n = 6'd19;  6'd46: n = 6'd46;
            default: n = i - 6'd2;
        endcase
        return n;
    endfunction

    function automatic logic mps_switch(input logic [5:0] i);
        return (i == 6'd0) || (i == 6'd6) || (i == 6'd14);
    endfunction

endpackage

>>> rtl/mqd_byte_queue.sv
// ----------------------------------------------------------------------------
// MQ decoder byte queue
// Circular byte FIFO with head peek; pops on empty are ignored.
// ----------------------------------------------------------------------------
module mqd_byte_queue
    import mqd_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [7:0]      i_data,
    input  logic            i_pop,
    output logic [7:0]      o_head,
    output t_q_status       o_status
);

    logic [7:0]        r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_head;
    logic [QPTR_W-1:0] r_tail;
    logic [QCNT_W-1:0] r_count;
    logic              w_push;
    logic              w_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign w_push         = i_push & ~o_status.full;
    assign w_pop          = i_pop & ~o_status.empty;
    assign o_head         = r_mem[r_head];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_tail] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (w_push) begin
                r_tail <= (r_tail == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_tail + 1'b1;
            end
            if (w_pop) begin
                r_head <= (r_head == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_head + 1'b1;
            end
            r_count <= r_count + QCNT_W'(w_push) - QCNT_W'(w_pop);
        end
    end

endmodule

>>> rtl/mq_arithmetic_decoder_unit.sv
// ----------------------------------------------------------------------------
// MQ arithmetic decoder unit
// Push, clear and raw start complete in the idle state; a raw bit passes
// through S_RAW, an MQ start through S_ST0 and S_ST1, and an MQ decision
// through S_DEC and, when renormalization is needed, S_REN, which shifts one
// bit at a time (up to 16 shifts). Results sit in an output register until
// taken. Synchronous active-low reset restores contexts, interval 0x8000, empty queue.
// ----------------------------------------------------------------------------
module mq_arithmetic_decoder_unit
    import mqd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [2:0] i_command,
    input  logic [7:0] i_byte_value,
    input  logic [4:0] i_context_req,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_decoded_bit,
    output logic       o_underflow,
    output logic       o_dropped_byte
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_ST0  = 3'd1;
    localparam logic [2:0] S_ST1  = 3'd2;
    localparam logic [2:0] S_DEC  = 3'd3;
    localparam logic [2:0] S_REN  = 3'd4;
    localparam logic [2:0] S_RAW  = 3'd5;

    logic [2:0]  r_state, n_state;
    logic [6:0]  r_ctx [NUM_CONTEXTS];
    logic [4:0]  r_cx;
    logic [15:0] r_int, n_int;
    logic [31:0] r_code, n_code;
    logic [3:0]  r_bc, n_bc;
    logic [7:0]  r_last, n_last;
    logic [3:0]  r_guard, n_guard;
    logic        r_bit, n_bit;
    logic        r_under_seen, n_under_seen;
    logic        r_drop, n_drop;
    logic        r_ov, n_ov;
    logic        r_obit, n_obit;
    logic        r_ounder, n_ounder;
    logic        r_odrop, n_odrop;

    logic        w_acc;
    logic        w_push;
    logic        w_pop;
    logic [7:0]  w_head;
    t_q_status   w_qs;
    logic [7:0]  w_peek;
    logic        w_clear;
    logic        w_ctx_we;
    logic [6:0]  w_ctx_wd;

    logic        f_pop;
    logic [7:0]  f_last;
    logic [31:0] f_add;
    logic [3:0]  f_bc;

    logic [6:0]  d_e;
    logic [5:0]  d_idx;
    logic        d_mps;
    logic [15:0] d_qe;
    logic [15:0] d_a;
    logic [31:0] t_code;
    logic [3:0]  t_bc;
    logic        t_under;
    logic        t_done;

    mqd_byte_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (i_byte_value),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_qs)
    );

    assign o_stall        = (r_state != S_IDLE) | (r_ov & i_stall);
    assign w_acc          = i_valid & ~o_stall;
    assign w_push         = w_acc & (i_command == CMD_PUSH);
    assign w_clear        = w_acc & (i_command == CMD_CLEAR);
    assign w_peek         = w_qs.empty ? 8'hFF : w_head;
    assign o_valid        = r_ov;
    assign o_decoded_bit  = r_obit;
    assign o_underflow    = r_ounder;
    assign o_dropped_byte = r_odrop;

    always_comb begin
        f_pop  = 1'b0;
        f_last = r_last;
        f_add  = 32'd0;
        f_bc   = 4'd8;
        if (r_last == 8'hFF) begin
            if (w_peek > 8'h8F) begin
                f_add = 32'h0000FF00;
            end else begin
                f_pop  = 1'b1;
                f_last = w_peek;
                f_add  = {15'd0, w_peek, 9'd0};
                f_bc   = 4'd7;
            end
        end else begin
            f_pop  = 1'b1;
            f_last = w_peek;
            f_add  = {16'd0, w_peek, 8'd0};
        end
    end

    always_comb begin
        d_e   = r_ctx[r_cx];
        d_idx = (d_e[5:0] >= 6'(NSTATES)) ? 6'(NSTATES - 1) : d_e[5:0];
        d_mps = d_e[6];
        d_qe  = prob_qe(d_idx);
        d_a   = r_int - d_qe;
    end

    always_comb begin
        n_state      = r_state;
        n_int        = r_int;
        n_code       = r_code;
        n_bc         = r_bc;
        n_last       = r_last;
        n_guard      = r_guard;
        n_bit        = r_bit;
        n_drop       = r_drop;
        n_ov         = r_ov;
        n_obit       = r_obit;
        n_ounder     = r_ounder;
        n_odrop      = r_odrop;
        w_pop        = 1'b0;
        w_ctx_we     = 1'b0;
        w_ctx_wd     = d_e;
        t_code       = r_code;
        t_bc         = r_bc;
        t_under      = 1'b0;
        t_done       = 1'b0;

        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    case (i_command)
                        CMD_PUSH: begin
                            if (w_qs.full) begin
                                n_drop = 1'b1;
                            end
                        end
                        CMD_START_MQ: n_state = S_ST0;
                        CMD_START_RAW: begin
                            n_code = 32'd0;
                            n_bc   = 4'd0;
                        end
                        CMD_DEC_MQ:  n_state = S_DEC;
                        CMD_DEC_RAW: n_state = S_RAW;
                        default: ;
                    endcase
                end
            end
            S_ST0: begin
                w_pop   = 1'b1;
                t_under = w_qs.empty;
                n_last  = w_peek;
                n_code  = {8'd0, w_peek, 16'd0};
                n_state = S_ST1;
            end
            S_ST1: begin
                w_pop   = f_pop;
                t_under = w_qs.empty;
                n_last  = f_last;
                t_code  = r_code + f_add;
                n_code  = {t_code[24:0], 7'd0};
                n_bc    = f_bc - 4'd7;
                n_int   = 16'h8000;
                n_state = S_IDLE;
            end
            S_DEC: begin
                n_guard = 4'd0;
                if (r_cx >= 5'(NUM_CONTEXTS)) begin
                    n_bit  = 1'b0;
                    t_done = 1'b1;
                end else begin
                    n_bit = d_mps;
                    if (r_code[31:16] < d_qe) begin
                        w_ctx_we = 1'b1;
                        n_int    = d_qe;
                        if (d_a < d_qe) begin
                            w_ctx_wd = {d_mps, next_mps(d_idx)};
                        end else begin
                            n_bit    = ~d_mps;
                            w_ctx_wd = {d_mps ^ mps_switch(d_idx), next_lps(d_idx)};
                        end
                        n_state = S_REN;
                    end else begin
                        n_code = r_code - {d_qe, 16'd0};
                        n_int  = d_a;
                        if (!d_a[15]) begin
                            w_ctx_we = 1'b1;
                            if (d_a < d_qe) begin
                                n_bit    = ~d_mps;
                                w_ctx_wd = {d_mps ^ mps_switch(d_idx), next_lps(d_idx)};
                            end else begin
                                w_ctx_wd = {d_mps, next_mps(d_idx)};
                            end
                            n_state = S_REN;
                        end else begin
                            t_done = 1'b1;
                        end
                    end
                end
            end
            S_REN: begin
                if (r_bc == 4'd0) begin
                    w_pop   = f_pop;
                    t_under = w_qs.empty;
                    n_last  = f_last;
                    t_code  = r_code + f_add;
                    t_bc    = f_bc;
                end
                n_int   = {r_int[14:0], 1'b0};
                n_code  = {t_code[30:0], 1'b0};
                n_bc    = t_bc - 4'd1;
                n_guard = r_guard + 4'd1;
                t_done  = r_int[14] | (r_guard == 4'd15);
            end
            S_RAW: begin
                t_code = r_code;
                if (r_bc == 4'd0) begin
                    t_under = w_qs.empty;
                    t_bc    = 4'd8;
                    if (r_code == 32'h000000FF) begin
                        if (w_peek != 8'hFF) begin
                            w_pop = 1'b1;
                            t_bc  = 4'd7;
                        end
                    end else begin
                        w_pop = 1'b1;
                    end
                    t_code = {24'd0, w_peek};
                    n_last = w_peek;
                end
                n_code = t_code;
                n_bc   = t_bc - 4'd1;
                n_bit  = t_code[{1'b0, n_bc}];
                t_done = 1'b1;
            end
            default: n_state = S_IDLE;
        endcase

        n_under_seen = r_under_seen | t_under;
        if (t_done) begin
            n_state      = S_IDLE;
            n_ov         = 1'b1;
            n_obit       = n_bit;
            n_ounder     = n_under_seen;
            n_odrop      = r_drop;
            n_under_seen = 1'b0;
            n_drop       = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_cx <= i_context_req;
        end
        r_bit    <= n_bit;
        r_obit   <= n_obit;
        r_ounder <= n_ounder;
        r_odrop  <= n_odrop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_int        <= 16'h8000;
            r_code       <= 32'd0;
            r_bc         <= 4'd0;
            r_last       <= 8'd0;
            r_guard      <= 4'd0;
            r_under_seen <= 1'b0;
            r_drop       <= 1'b0;
            r_ov         <= 1'b0;
            for (int k = 0; k < NUM_CONTEXTS; k++) begin
                r_ctx[k] <= ctx_init(k);
            end
        end else begin
            r_state      <= n_state;
            r_int        <= n_int;
            r_code       <= n_code;
            r_bc         <= n_bc;
            r_last       <= n_last;
            r_guard      <= n_guard;
            r_under_seen <= n_under_seen;
            r_drop       <= n_drop;
            r_ov         <= n_ov;
            if (w_clear) begin
                for (int k = 0; k < NUM_CONTEXTS; k++) begin
                    r_ctx[k] <= ctx_init(k);
                end
            end else if (w_ctx_we) begin
                r_ctx[r_cx] <= w_ctx_wd;
            end
        end
    end

endmodule
